FILE: src/lcq_pkg.sv
// Package for the linked-block channel queues: sizes, derived widths,
// shared types and status codes. Used by every module under src but lcq_pool_ram.
// Depends on nothing.
package lcq_pkg;

  localparam int unsigned NumBlocks     = 32;
  localparam int unsigned BlockSizeLog2 = 4;
  localparam int unsigned NumChannels   = 8;

  localparam int unsigned BlkW     = $clog2(NumBlocks);
  localparam int unsigned PoolAw   = BlkW + BlockSizeLog2;
  localparam int unsigned PoolDepth = NumBlocks << BlockSizeLog2;
  localparam int unsigned ChIdxW   = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  localparam int unsigned FuncW    = 1;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned DataW    = 8;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CountW   = 9;

  localparam logic [CountW-1:0] CountMax      = 9'd511;
  localparam logic [CountW-1:0] LimitReset    = 9'd511;
  localparam logic [DataW-1:0]  NumBlocksByte = DataW'(NumBlocks);
  localparam logic [4:0]        ChanLimit     = 5'(NumChannels);

  localparam logic [FuncW-1:0] FuncPut = 1'b0;
  localparam logic [FuncW-1:0] FuncGet = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StOk        = 3'd0,
    StOverLimit = 3'd1,
    StNoBlock   = 3'd2,
    StEmpty     = 3'd3,
    StBroken    = 3'd4
  } status_e;

  // Per-channel bookkeeping: active flag, read pointer, write pointer, byte count.
  typedef struct packed {
    logic              active;
    logic [PoolAw-1:0] head;
    logic [PoolAw-1:0] tail;
    logic [CountW-1:0] count;
  } chan_t;

  // Block allocation request: take the lowest free block and/or give one back.
  typedef struct packed {
    logic            take;
    logic            give;
    logic [BlkW-1:0] give_blk;
  } fm_ctrl_t;

endpackage

FILE: src/linked_block_channel_queues.sv
// Top level of the linked-block channel queues: command sequencer and result
// register. Depends on lcq_pkg, lcq_pool_ram, lcq_free_map, lcq_chan_table.
//
// Usage
//   Command channel: drive func_i, channel_i and data_byte_i with start high;
//   the transaction is taken at the rising edge where start is high and busy
//   is low. Put (func 0) appends data_byte_i, get (func 1) removes the oldest
//   byte of the channel.
//   Result channel: result_valid_o is high for exactly one cycle per
//   transaction, with status_o, read_byte_o and channel_count_o. The receiver
//   cannot stall it and must take the result in that cycle.
//   Configuration: cfg_data_i is written to the channel limit when cfg_valid_i
//   is high; cfg_ready_o is always high. Write it only while the block is idle.
// Sequence
//   A put inside its block, or one that opens a first block, ends in S_EXEC; a
//   put that opens a next block ends in S_PUT2. A get reads in S_EXEC and ends
//   in S_GDATA, passing S_LINK first when it follows a link. busy drops as the
//   result shows, so no command is taken before then. Each link costs one more
//   write on the single pool write port (put) or one more registered read (get).
// Reset
//   All blocks free, every channel inactive with count zero, limit 511. The
//   pool RAM is not cleared; entries are only read after they are written.
module linked_block_channel_queues (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [lcq_pkg::FuncW-1:0]     func_i,
  input  logic [lcq_pkg::ChanW-1:0]     channel_i,
  input  logic [lcq_pkg::DataW-1:0]     data_byte_i,
  // result channel
  output logic                          result_valid_o,
  output logic [lcq_pkg::StatusW-1:0]   status_o,
  output logic [lcq_pkg::DataW-1:0]     read_byte_o,
  output logic [lcq_pkg::CountW-1:0]    channel_count_o,
  // configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lcq_pkg::CountW-1:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PUT2,
    S_LINK,
    S_GDATA
  } state_e;

  state_e state_q, state_d;

  // Latched command
  logic [lcq_pkg::FuncW-1:0]  cmd_func_q;
  logic [lcq_pkg::ChanW-1:0]  cmd_chan_q;
  logic [lcq_pkg::DataW-1:0]  cmd_data_q;

  // Result registers
  logic                        res_valid_q;
  lcq_pkg::status_e            res_status_q;
  logic [lcq_pkg::DataW-1:0]   res_byte_q;
  logic [lcq_pkg::CountW-1:0]  res_count_q;

  logic [lcq_pkg::CountW-1:0]  limit_q;

  // Completion of the current transaction, computed by the sequencer
  logic                        fin;
  lcq_pkg::status_e            fin_status;
  logic [lcq_pkg::DataW-1:0]   fin_byte;
  logic [lcq_pkg::CountW-1:0]  fin_count;

  // Channel table access
  logic [4:0]                  chan_wide;
  logic                        in_range;
  logic [lcq_pkg::ChIdxW-1:0]  chan_idx;
  lcq_pkg::chan_t              cur, nxt;
  logic                        chan_we;

  // Free map access
  lcq_pkg::fm_ctrl_t           fm_ctrl;
  logic                        any_free;
  logic [lcq_pkg::BlkW-1:0]    low_blk;

  // Pool RAM access
  logic                        ram_we, ram_re;
  logic [lcq_pkg::PoolAw-1:0]  ram_waddr, ram_raddr;
  logic [lcq_pkg::DataW-1:0]   ram_wdata, ram_rdata;

  // Scratch values
  logic [lcq_pkg::PoolAw-1:0]  low_addr, link_addr, head_inc;
  logic [lcq_pkg::CountW-1:0]  count_dec;

  assign chan_wide = 5'(cmd_chan_q);
  assign in_range  = chan_wide < lcq_pkg::ChanLimit;
  assign chan_idx  = chan_wide[lcq_pkg::ChIdxW-1:0];

  assign low_addr  = {low_blk, {lcq_pkg::BlockSizeLog2{1'b0}}};
  assign link_addr = {ram_rdata[lcq_pkg::BlkW-1:0], {lcq_pkg::BlockSizeLog2{1'b0}}};
  // The head never sits on a link byte when it is bumped, so no carry leaves the block.
  assign head_inc  = cur.head + lcq_pkg::PoolAw'(1);
  assign count_dec = cur.count - lcq_pkg::CountW'(1);

  lcq_chan_table u_chan_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .idx_i     (chan_idx),
    .wr_en_i   (chan_we),
    .wr_data_i (nxt),
    .rd_data_o (cur)
  );

  lcq_free_map u_free_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (fm_ctrl),
    .any_free_o (any_free),
    .low_blk_o  (low_blk)
  );

  lcq_pool_ram #(
    .Depth (lcq_pkg::PoolDepth),
    .Width (lcq_pkg::DataW)
  ) u_pool_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // Sequencer. Each state issues at most one pool write or one pool read.
  // The end mark of a freshly taken block is not stored: a link byte is only
  // read while bytes remain past it, and then a put has already written it.
  always_comb begin
    state_d    = state_q;
    fin        = 1'b0;
    fin_status = lcq_pkg::StOk;
    fin_byte   = '0;
    fin_count  = '0;
    nxt        = cur;
    chan_we    = 1'b0;
    fm_ctrl    = '0;
    ram_we     = 1'b0;
    ram_waddr  = cur.tail;
    ram_wdata  = cmd_data_q;
    ram_re     = 1'b0;
    ram_raddr  = cur.head;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (!in_range) begin
          // Unknown channel: touch nothing
          fin        = 1'b1;
          fin_status = (cmd_func_q == lcq_pkg::FuncGet) ? lcq_pkg::StEmpty
                                                        : lcq_pkg::StOverLimit;
        end else if (cmd_func_q == lcq_pkg::FuncPut) begin
          if (cur.count > limit_q || cur.count == lcq_pkg::CountMax) begin
            fin        = 1'b1;
            fin_status = lcq_pkg::StOverLimit;
            fin_count  = cur.count;
          end else if (!cur.active) begin
            if (!any_free) begin
              nxt        = '0;
              chan_we    = 1'b1;
              fin        = 1'b1;
              fin_status = lcq_pkg::StNoBlock;
            end else begin
              // Open the first block and store the byte at its start
              fm_ctrl.take = 1'b1;
              ram_we       = 1'b1;
              ram_waddr    = low_addr;
              nxt.active   = 1'b1;
              nxt.head     = low_addr;
              nxt.tail     = low_addr + lcq_pkg::PoolAw'(1);
              nxt.count    = lcq_pkg::CountW'(1);
              chan_we      = 1'b1;
              fin          = 1'b1;
              fin_count    = lcq_pkg::CountW'(1);
            end
          end else if (&cur.tail[lcq_pkg::BlockSizeLog2-1:0]) begin
            if (!any_free) begin
              fin        = 1'b1;
              fin_status = lcq_pkg::StNoBlock;
              fin_count  = cur.count;
            end else begin
              // Link the next block into the chain, store the byte next cycle
              fm_ctrl.take = 1'b1;
              ram_we       = 1'b1;
              ram_wdata    = lcq_pkg::DataW'(low_blk);
              nxt.tail     = low_addr;
              chan_we      = 1'b1;
              state_d      = S_PUT2;
            end
          end else begin
            ram_we    = 1'b1;
            nxt.tail  = cur.tail + lcq_pkg::PoolAw'(1);
            nxt.count = cur.count + lcq_pkg::CountW'(1);
            chan_we   = 1'b1;
            fin       = 1'b1;
            fin_count = nxt.count;
          end
        end else begin
          if (cur.count == '0) begin
            if (cur.active) begin
              fm_ctrl.give     = 1'b1;
              fm_ctrl.give_blk = cur.head[lcq_pkg::PoolAw-1:lcq_pkg::BlockSizeLog2];
            end
            nxt        = '0;
            chan_we    = 1'b1;
            fin        = 1'b1;
            fin_status = lcq_pkg::StEmpty;
          end else if (&cur.head[lcq_pkg::BlockSizeLog2-1:0]) begin
            // Leave the block: free it and fetch its link
            fm_ctrl.give     = 1'b1;
            fm_ctrl.give_blk = cur.head[lcq_pkg::PoolAw-1:lcq_pkg::BlockSizeLog2];
            ram_re           = 1'b1;
            state_d          = S_LINK;
          end else begin
            ram_re  = 1'b1;
            state_d = S_GDATA;
          end
        end
      end

      S_PUT2: begin
        ram_we    = 1'b1;
        nxt.tail  = cur.tail + lcq_pkg::PoolAw'(1);
        nxt.count = cur.count + lcq_pkg::CountW'(1);
        chan_we   = 1'b1;
        fin       = 1'b1;
        fin_count = nxt.count;
      end

      S_LINK: begin
        if (ram_rdata >= lcq_pkg::NumBlocksByte) begin
          nxt        = '0;
          chan_we    = 1'b1;
          fin        = 1'b1;
          fin_status = lcq_pkg::StBroken;
        end else begin
          nxt.head  = link_addr;
          chan_we   = 1'b1;
          ram_re    = 1'b1;
          ram_raddr = link_addr;
          state_d   = S_GDATA;
        end
      end

      S_GDATA: begin
        fin      = 1'b1;
        fin_byte = ram_rdata;
        if (count_dec == '0) begin
          // Last byte gone: release the block and retire the channel
          fm_ctrl.give     = 1'b1;
          fm_ctrl.give_blk = head_inc[lcq_pkg::PoolAw-1:lcq_pkg::BlockSizeLog2];
          nxt              = '0;
        end else begin
          nxt.head  = head_inc;
          nxt.count = count_dec;
          fin_count = count_dec;
        end
        chan_we = 1'b1;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = S_IDLE;
    end
  end

  // State, latched command and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_valid_q  <= 1'b0;
      res_status_q <= lcq_pkg::StOk;
      res_byte_q   <= '0;
      res_count_q  <= '0;
      cmd_func_q   <= lcq_pkg::FuncPut;
      cmd_chan_q   <= '0;
      cmd_data_q   <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= fin;
      if (fin) begin
        res_status_q <= fin_status;
        res_byte_q   <= fin_byte;
        res_count_q  <= fin_count;
      end
      if (state_q == S_IDLE && start) begin
        cmd_func_q <= func_i;
        cmd_chan_q <= channel_i;
        cmd_data_q <= data_byte_i;
      end
    end
  end

  // Channel limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lcq_pkg::LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign busy            = (state_q != S_IDLE);
  assign result_valid_o  = res_valid_q;
  assign status_o        = res_status_q;
  assign read_byte_o     = res_byte_q;
  assign channel_count_o = res_count_q;

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (state_q == S_IDLE))
    else $error("result shown while a transaction is still in flight");

  a_read_before_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK || state_q == S_GDATA) |-> $past(ram_re))
    else $error("pool data used without a read in the previous cycle");

  a_failed_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_status_q != lcq_pkg::StOk) |-> (res_byte_q == '0))
    else $error("refused transaction returned a byte");

endmodule

FILE: src/lcq_pool_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. Holds the shared block pool. No dependencies.
module lcq_pool_ram #(
  parameter int unsigned Depth = 512,
  parameter int unsigned Width = 8,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [Aw-1:0]    wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [Aw-1:0]    rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

FILE: src/lcq_free_map.sv
// Free-block bitmap with lowest-free-first selection.
// Depends on lcq_pkg.
module lcq_free_map (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lcq_pkg::fm_ctrl_t           ctrl_i,
  output logic                        any_free_o,
  output logic [lcq_pkg::BlkW-1:0]    low_blk_o
);

  logic [lcq_pkg::NumBlocks-1:0] map_q, map_d;

  // Lowest set bit wins.
  always_comb begin
    low_blk_o = '0;
    for (int i = lcq_pkg::NumBlocks - 1; i >= 0; i--) begin
      if (map_q[i]) begin
        low_blk_o = lcq_pkg::BlkW'(i);
      end
    end
  end

  assign any_free_o = |map_q;

  always_comb begin
    map_d = map_q;
    if (ctrl_i.take) begin
      map_d[low_blk_o] = 1'b0;
    end
    if (ctrl_i.give) begin
      map_d[ctrl_i.give_blk] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '1;
    end else begin
      map_q <= map_d;
    end
  end

  a_take_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.take |-> any_free_o)
    else $error("block taken with no free block");

  a_give_held_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.give |-> !map_q[ctrl_i.give_blk])
    else $error("block given back while already free");

endmodule

FILE: src/lcq_chan_table.sv
// Per-channel pointer and count registers, one read and one write at the
// selected channel. Depends on lcq_pkg.
module lcq_chan_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [lcq_pkg::ChIdxW-1:0]   idx_i,
  input  logic                         wr_en_i,
  input  lcq_pkg::chan_t               wr_data_i,
  output lcq_pkg::chan_t               rd_data_o
);

  lcq_pkg::chan_t chan_q [lcq_pkg::NumChannels];

  assign rd_data_o = chan_q[idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lcq_pkg::NumChannels; i++) begin
        chan_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      chan_q[idx_i] <= wr_data_i;
    end
  end

endmodule
